/* hdl/smbf_pkg.sv */
// shared types, constants and a lookup function for the sip message boundary finder
`timescale 1ns / 1ps
`default_nettype none
package smbf_pkg;

   // byte queue between front and back
   localparam int QUEUE_DEPTH       = 4;
   localparam int QUEUE_PTR_BITS    = 2;
   localparam int QUEUE_COUNT_BITS  = QUEUE_PTR_BITS + 1;

   // value text longer than this is flagged
   localparam int MAX_VALUE_CHARS   = 11;
   localparam int FIELD_LEN         = 16;
   localparam int VALUE_BITS        = 17;
   localparam logic [VALUE_BITS-1:0] VALUE_SATURATED = 17'd65536;

   // scanner phase codes
   localparam logic [2:0] PH_SEEK_FIELD = 3'd0;
   localparam logic [2:0] PH_VAL_LEAD   = 3'd1;
   localparam logic [2:0] PH_VAL_DIGITS = 3'd2;
   localparam logic [2:0] PH_VAL_STOP   = 3'd3;
   localparam logic [2:0] PH_SEEK_END   = 3'd4;
   localparam logic [2:0] PH_END_FOUND  = 3'd5;

   // sign codes
   localparam logic [1:0] SIGN_NONE  = 2'd0;
   localparam logic [1:0] SIGN_PLUS  = 2'd1;
   localparam logic [1:0] SIGN_MINUS = 2'd2;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_VT    = 8'h0b;
   localparam logic [7:0] CHAR_FF    = 8'h0c;
   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // one classified byte as it waits in the queue
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       is_cr;
      logic       is_lf;
      logic       is_nul;
      logic       is_blank;
      logic       is_digit;
      logic       is_plus;
      logic       is_minus;
      logic [3:0] digit;
   } byte_item_type;

   // one result, packed as it leaves on the result channel
   typedef struct packed {
      logic        too_long;
      logic [15:0] length;
      logic        complete;
   } result_type;

   // text of the header name being searched for
   function automatic logic [7:0] field_char(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0:    c = 8'h43; // C
         4'd1:    c = 8'h6f; // o
         4'd2:    c = 8'h6e; // n
         4'd3:    c = 8'h74; // t
         4'd4:    c = 8'h65; // e
         4'd5:    c = 8'h6e; // n
         4'd6:    c = 8'h74; // t
         4'd7:    c = 8'h2d; // -
         4'd8:    c = 8'h4c; // L
         4'd9:    c = 8'h65; // e
         4'd10:   c = 8'h6e; // n
         4'd11:   c = 8'h67; // g
         4'd12:   c = 8'h74; // t
         4'd13:   c = 8'h68; // h
         4'd14:   c = 8'h3a; // :
         4'd15:   c = 8'h20; // space
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

/* hdl/smbf_front.sv */
// front end: accepts bytes, classifies them and queues them for the scanner
`timescale 1ns / 1ps
`default_nettype none
module smbf_front
   import smbf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [7:0]    req_tdata,
   input  wire logic          req_tlast,
   output logic               head_valid,
   output byte_item_type      head,
   input  wire logic          pop
);

   byte_item_type                   queue_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_BITS-1:0]     count_ff, count_in;
   logic                            push;
   byte_item_type                   classified;

   // classify the incoming byte
   always_comb begin
      classified.data     = req_tdata;
      classified.last     = req_tlast;
      classified.is_cr    = (req_tdata == CHAR_CR);
      classified.is_lf    = (req_tdata == CHAR_LF);
      classified.is_nul   = (req_tdata == CHAR_NUL);
      classified.is_blank = (req_tdata == CHAR_SPACE) || (req_tdata == CHAR_TAB) ||
                            (req_tdata == CHAR_LF) || (req_tdata == CHAR_VT) ||
                            (req_tdata == CHAR_FF) || (req_tdata == CHAR_CR);
      classified.is_digit = (req_tdata >= CHAR_ZERO) && (req_tdata <= CHAR_NINE);
      classified.is_plus  = (req_tdata == CHAR_PLUS);
      classified.is_minus = (req_tdata == CHAR_MINUS);
      classified.digit    = req_tdata[3:0];
   end

   assign req_tready = (count_ff != QUEUE_COUNT_BITS'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign head_valid = (count_ff != '0);
   assign head       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= classified;
      end
   end

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_COUNT_BITS'(QUEUE_DEPTH))
      else $error("byte queue holds more than its depth");

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("scanner took a byte from an empty queue");

endmodule
`default_nettype wire

/* hdl/smbf_back.sv */
// back end: per-byte scanner for keep-alive run, content length and header end
`timescale 1ns / 1ps
`default_nettype none
module smbf_back
   import smbf_pkg::*;
#(
   parameter int POS_BITS = 16
)
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          head_valid,
   input  wire byte_item_type head,
   output logic               pop,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output result_type         rsp_result
);

   localparam int WIDE_BITS = ((POS_BITS > VALUE_BITS) ? POS_BITS : VALUE_BITS) + 1;

   typedef struct packed {
      logic [2:0]            phase;
      logic [VALUE_BITS-1:0] acc;
      logic [3:0]            cnt;
      logic [1:0]            sign;
   } value_state_type;

   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic                  in_ka_ff, in_ka_in;
   logic [POS_BITS-1:0]   ka_ff, ka_in;
   logic                  pend_cr_ff, pend_cr_in;
   logic [4:0]            fmc_ff, fmc_in;
   logic [2:0]            term_ff, term_in;
   logic [POS_BITS-1:0]   hdr_ff, hdr_in;
   value_state_type       vs_ff, vs_in, vs_mid;
   logic                  overlong;
   logic [POS_BITS-1:0]   total;
   logic [WIDE_BITS-1:0]  end_wide;
   logic [WIDE_BITS-1:0]  ka_wide;
   logic                  flag;
   result_type            verdict;
   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_result_ff;

   // one character of the value text; blank-only call for a carriage return
   function automatic value_state_type take_char(
      input value_state_type s,
      input logic            blank,
      input logic            plus,
      input logic            minus,
      input logic            dig,
      input logic [3:0]      dval
   );
      value_state_type r;
      logic [20:0]     prod;
      r    = s;
      prod = {s.acc, 3'b000} + {2'b00, s.acc, 1'b0} + {17'd0, dval};
      if (s.cnt != 4'd15) begin
         r.cnt = s.cnt + 4'd1;
      end
      case (s.phase)
         PH_VAL_LEAD: begin
            if (!blank) begin
               if (plus) begin
                  r.sign  = SIGN_PLUS;
                  r.phase = PH_VAL_DIGITS;
               end else if (minus) begin
                  r.sign  = SIGN_MINUS;
                  r.phase = PH_VAL_DIGITS;
               end else if (dig) begin
                  r.acc   = {13'd0, dval};
                  r.phase = PH_VAL_DIGITS;
               end else begin
                  r.phase = PH_VAL_STOP;
               end
            end
         end
         PH_VAL_DIGITS: begin
            if (dig) begin
               if (prod > {4'd0, VALUE_SATURATED}) begin
                  r.acc = VALUE_SATURATED;
               end else begin
                  r.acc = prod[VALUE_BITS-1:0];
               end
            end else begin
               r.phase = PH_VAL_STOP;
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   assign pop      = head_valid && (!head.last || !rsp_valid_ff || rsp_tready);
   assign overlong = (pos_ff == '1);
   assign total    = pos_ff + 1'b1;

   // next scanner state, including the final byte of a buffer
   always_comb begin
      pos_in     = pos_ff;
      in_ka_in   = in_ka_ff;
      ka_in      = ka_ff;
      pend_cr_in = pend_cr_ff;
      fmc_in     = fmc_ff;
      term_in    = term_ff;
      hdr_in     = hdr_ff;
      vs_in      = vs_ff;
      vs_mid     = vs_ff;

      if (pop && !overlong) begin
         pos_in = total;

         // keep-alive run of crlf pairs and zero bytes
         if (in_ka_ff) begin
            if (pend_cr_ff) begin
               pend_cr_in = 1'b0;
               if (head.is_lf) begin
                  ka_in = ka_ff + POS_BITS'(2);
               end else begin
                  in_ka_in = 1'b0;
               end
            end else if (head.is_cr) begin
               pend_cr_in = 1'b1;
            end else if (head.is_nul) begin
               ka_in = ka_ff + POS_BITS'(1);
            end else begin
               in_ka_in = 1'b0;
            end
         end

         case (vs_ff.phase)
            PH_SEEK_FIELD: begin
               if (fmc_ff < 5'(FIELD_LEN) && head.data == field_char(fmc_ff[3:0])) begin
                  fmc_in = fmc_ff + 5'd1;
               end else begin
                  fmc_in = (head.data == field_char(4'd0)) ? 5'd1 : 5'd0;
               end
               if (fmc_in >= 5'(FIELD_LEN)) begin
                  vs_in.phase = PH_VAL_LEAD;
               end
            end
            PH_VAL_LEAD, PH_VAL_DIGITS, PH_VAL_STOP: begin
               if (term_ff == 3'd1) begin
                  if (head.is_lf) begin
                     term_in     = 3'd2;
                     vs_in.phase = PH_SEEK_END;
                  end else begin
                     // held carriage return turns out to be value text
                     vs_mid = take_char(vs_ff, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0);
                     vs_in  = vs_mid;
                     if (!head.is_cr) begin
                        term_in = 3'd0;
                        vs_in   = take_char(vs_mid, head.is_blank, head.is_plus,
                                            head.is_minus, head.is_digit, head.digit);
                     end
                  end
               end else if (head.is_cr) begin
                  term_in = 3'd1;
               end else begin
                  vs_in = take_char(vs_ff, head.is_blank, head.is_plus,
                                    head.is_minus, head.is_digit, head.digit);
               end
            end
            PH_SEEK_END: begin
               if (head.is_cr) begin
                  term_in = (term_ff == 3'd2) ? 3'd3 : 3'd1;
               end else if (head.is_lf && (term_ff == 3'd1 || term_ff == 3'd3)) begin
                  term_in = term_ff + 3'd1;
               end else begin
                  term_in = 3'd0;
               end
               if (term_in == 3'd4) begin
                  hdr_in      = total;
                  vs_in.phase = PH_END_FOUND;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // verdict at the final byte; value, count and sign cannot move once the
   // header end search has begun, so the stored copies serve here
   always_comb begin
      verdict  = '0;
      flag     = 1'b0;
      ka_wide  = WIDE_BITS'(ka_in);
      end_wide = WIDE_BITS'(hdr_in) + WIDE_BITS'(vs_ff.acc);
      if (!overlong) begin
         if (ka_in != '0) begin
            if (ka_wide <= WIDE_BITS'(16'hffff)) begin
               verdict.complete = 1'b1;
               verdict.length   = ka_wide[15:0];
            end
         end else begin
            flag = (vs_in.phase == PH_SEEK_END || vs_in.phase == PH_END_FOUND) &&
                   (vs_ff.cnt > 4'(MAX_VALUE_CHARS));
            verdict.too_long = flag;
            if (vs_in.phase == PH_END_FOUND && !flag &&
                !(vs_ff.sign == SIGN_MINUS && vs_ff.acc != '0)) begin
               if (end_wide <= WIDE_BITS'(total) &&
                   end_wide <= WIDE_BITS'(16'hffff)) begin
                  verdict.complete = 1'b1;
                  verdict.length   = end_wide[15:0];
               end
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (pop && head.last) begin
         rsp_valid_in = 1'b1;
      end
   end

   // end of buffer: everything back to its reset value
   always_ff @(posedge clock) begin
      if (reset || (pop && head.last)) begin
         pos_ff       <= '0;
         in_ka_ff     <= 1'b1;
         ka_ff        <= '0;
         pend_cr_ff   <= 1'b0;
         fmc_ff       <= '0;
         term_ff      <= '0;
         hdr_ff       <= '0;
         vs_ff        <= '{phase: PH_SEEK_FIELD, acc: '0, cnt: '0, sign: SIGN_NONE};
      end else begin
         pos_ff       <= pos_in;
         in_ka_ff     <= in_ka_in;
         ka_ff        <= ka_in;
         pend_cr_ff   <= pend_cr_in;
         fmc_ff       <= fmc_in;
         term_ff      <= term_in;
         hdr_ff       <= hdr_in;
         vs_ff        <= vs_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && head.last) begin
         rsp_result_ff <= verdict;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !(pop && head.last))
      else $error("result overwritten while still waiting");

   a_incomplete_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_result_ff.complete |-> rsp_result_ff.length == '0)
      else $error("incomplete result carries a length");

   a_flag_not_complete: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_result_ff.complete |-> !rsp_result_ff.too_long)
      else $error("complete result with overlong value text");

endmodule
`default_nettype wire

/* hdl/sip_message_boundary_finder_unit.sv */
// top level of the sip message boundary finder
`timescale 1ns / 1ps
`default_nettype none
// throughput: one byte per cycle sustained, limited by the single-byte scanner step,
//   except while a final byte waits for the previous result to be taken
// result: the scanner step that pops the queued last byte loads the result register
// a four-entry queue between classifier and scanner absorbs result-side stalls; a final
//   byte waits in it while the previous result has not been taken
// reset: synchronous, active high; empties the queue, returns the scanner to the
//   start of a buffer and drops any pending result; no clearing pass
module sip_message_boundary_finder_unit
   import smbf_pkg::*;
#(
   parameter int BUFFER_POSITION_BITS = 16
)
(
   input  wire logic          clock,
   input  wire logic          reset,
   // byte stream in
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [7:0]    req_tdata,   // [7:0] data_byte
   input  wire logic          req_tlast,   // last_byte: final byte of the buffer
   // one result per buffer
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [23:0]        rsp_tdata    // [0] complete, [16:1] message_length,
                                           // [17] length_text_too_long, [23:18] zero
);

   // classified byte at the head of the queue
   logic           head_valid;
   byte_item_type  head;
   logic           pop;
   result_type     rsp_result;

   // front: accept and classify each transaction, queue it
   smbf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   // back: scan one byte per cycle unless a final byte waits on an untaken result, hold the verdict until taken
   smbf_back #(
      .POS_BITS   (BUFFER_POSITION_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (rsp_result)
   );

   // result fields packed from bit 0 up, padded to whole bytes
   assign rsp_tdata = {6'b000000, rsp_result};

endmodule
`default_nettype wire

/* dv/sip_frame_monitor.sv */
// monitor that predicts the sip message boundary finder's answers and compares them
`timescale 1ns / 1ps
`default_nettype none
module sip_frame_monitor
   import smbf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [7:0]  req_tdata,
   input  wire logic        req_tlast,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [23:0] rsp_tdata,
   output int               mismatches,
   output int               answers_waiting
);

   localparam logic [127:0] LENGTH_NAME = "Content-Length: ";

   // scan state of the buffer in progress
   logic [15:0] pos;
   logic        ka_open;
   logic [15:0] ka_len;
   logic        ka_cr;
   logic [2:0]  phase;
   logic [4:0]  name_hits;
   logic [16:0] length_value;
   logic [3:0]  text_chars;
   logic [1:0]  sign;
   logic [2:0]  crlf_hits;
   logic [16:0] body_start;

   result_type  due_answers[$];

   function automatic logic [7:0] length_name_char(input logic [4:0] idx);
      return LENGTH_NAME[8 * (15 - idx) +: 8];
   endfunction

   function automatic void clear_scan();
      pos          = '0;
      ka_open      = 1'b1;
      ka_len       = '0;
      ka_cr        = 1'b0;
      phase        = PH_SEEK_FIELD;
      name_hits    = '0;
      length_value = '0;
      text_chars   = '0;
      sign         = SIGN_NONE;
      crlf_hits    = '0;
      body_start   = '0;
   endfunction

   function automatic void take_length_char(input logic [7:0] c);
      logic        digit;
      logic [31:0] grown;
      digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      if (text_chars != 4'd15) text_chars++;
      if (phase == PH_VAL_LEAD) begin
         if (c inside {CHAR_SPACE, CHAR_TAB, CHAR_LF, CHAR_VT, CHAR_FF, CHAR_CR}) return;
         if (c == CHAR_PLUS) begin
            sign  = SIGN_PLUS;
            phase = PH_VAL_DIGITS;
         end else if (c == CHAR_MINUS) begin
            sign  = SIGN_MINUS;
            phase = PH_VAL_DIGITS;
         end else if (digit) begin
            length_value = 17'(c - CHAR_ZERO);
            phase        = PH_VAL_DIGITS;
         end else begin
            phase = PH_VAL_STOP;
         end
      end else if (phase == PH_VAL_DIGITS) begin
         if (digit) begin
            grown = 32'(length_value) * 32'd10 + 32'(c - CHAR_ZERO);
            length_value = (grown > 32'(VALUE_SATURATED)) ? VALUE_SATURATED : grown[16:0];
         end else begin
            phase = PH_VAL_STOP;
         end
      end
   endfunction

   function automatic void track_keepalive(input logic [7:0] b);
      if (!ka_open) return;
      if (ka_cr) begin
         ka_cr = 1'b0;
         if (b == CHAR_LF) ka_len += 16'd2;
         else ka_open = 1'b0;
      end else if (b == CHAR_CR) begin
         ka_cr = 1'b1;
      end else if (b == CHAR_NUL) begin
         ka_len += 16'd1;
      end else begin
         ka_open = 1'b0;
      end
   endfunction

   function automatic void track_headers(input logic [7:0] b);
      logic [2:0] k;
      case (phase)
         PH_SEEK_FIELD: begin
            if (name_hits < FIELD_LEN && b == length_name_char(name_hits)) name_hits++;
            else name_hits = (b == length_name_char(5'd0)) ? 5'd1 : 5'd0;
            if (name_hits >= FIELD_LEN) phase = PH_VAL_LEAD;
         end
         PH_VAL_LEAD, PH_VAL_DIGITS, PH_VAL_STOP: begin
            // a cr only belongs to the value once the byte after it is not lf
            if (crlf_hits == 3'd1) begin
               if (b == CHAR_LF) begin
                  crlf_hits = 3'd2;
                  phase     = PH_SEEK_END;
               end else begin
                  take_length_char(CHAR_CR);
                  if (b != CHAR_CR) begin
                     crlf_hits = 3'd0;
                     take_length_char(b);
                  end
               end
            end else if (b == CHAR_CR) begin
               crlf_hits = 3'd1;
            end else begin
               take_length_char(b);
            end
         end
         PH_SEEK_END: begin
            k = crlf_hits;
            if (b == CHAR_CR) k = (k == 3'd2) ? 3'd3 : 3'd1;
            else if (b == CHAR_LF && (k == 3'd1 || k == 3'd3)) k = k + 3'd1;
            else k = 3'd0;
            crlf_hits = k;
            if (k >= 3'd4) begin
               body_start = {1'b0, pos} + 17'd1;
               phase      = PH_END_FOUND;
            end
         end
         default: ;
      endcase
   endfunction

   task automatic frame_byte(input logic [7:0] b, input logic l,
                             output logic answered, output result_type ans);
      logic        overlong;
      logic        too_long;
      logic [17:0] msg_end;
      overlong = (pos == '1);
      answered = l;
      ans      = '0;
      if (!overlong) begin
         track_keepalive(b);
         track_headers(b);
         pos++;
      end
      if (l && !overlong) begin
         if (ka_len != 16'd0) begin
            ans.complete = 1'b1;
            ans.length   = ka_len;
         end else begin
            too_long     = (phase >= PH_SEEK_END) && (text_chars > MAX_VALUE_CHARS);
            ans.too_long = too_long;
            if (phase == PH_END_FOUND && !too_long &&
                !(sign == SIGN_MINUS && length_value != '0)) begin
               msg_end = 18'(body_start) + 18'(length_value);
               if (msg_end <= 18'(pos) && msg_end <= 18'hffff) begin
                  ans.complete = 1'b1;
                  ans.length   = msg_end[15:0];
               end
            end
         end
      end
      if (l) clear_scan();
   endtask

   task automatic report_mismatch(input string what, input logic [23:0] got,
                                  input logic [23:0] want);
      $display("%0t mismatch in %s: got %0h, want %0h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic check_answer(input logic [23:0] word);
      result_type seen;
      result_type due;
      if (due_answers.size() == 0) begin
         report_mismatch("result with none due", word, 24'd0);
         return;
      end
      seen = word[17:0];
      due  = due_answers.pop_front();
      if (seen.complete != due.complete)
         report_mismatch("complete", 24'(seen.complete), 24'(due.complete));
      if (seen.length != due.length)
         report_mismatch("message_length", 24'(seen.length), 24'(due.length));
      if (seen.too_long != due.too_long)
         report_mismatch("length_text_too_long", 24'(seen.too_long), 24'(due.too_long));
      if (word[23:18] != '0) report_mismatch("padding", 24'(word[23:18]), 24'd0);
   endtask

   always @(posedge clock) begin
      logic       answered;
      result_type ans;
      if (reset) begin
         clear_scan();
         due_answers.delete();
         mismatches = 0;
         answers_waiting <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_answer(rsp_tdata);
         if (req_tvalid && req_tready) begin
            frame_byte(req_tdata, req_tlast, answered, ans);
            if (answered) due_answers.push_back(ans);
         end
         answers_waiting <= due_answers.size();
      end
   end

endmodule
`default_nettype wire

/* dv/tb_top.sv */
// top of the sip message boundary finder testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   import smbf_pkg::*;

   // cycles without any transaction before the run is declared hung
   localparam int STALL_LIMIT    = 2000;
   // length of the one long result-side hold-off
   localparam int RSP_HOLD_CYCLES = 300;
   // byte count at which the run stops starting new buffers
   localparam int TOTAL_BYTES    = 1150;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;

   int mismatches;
   int answers_waiting;
   int quiet_cycles = 0;

   // bytes of the buffer being assembled for sending
   logic [7:0] frame_bytes[$];
   bit         sender_eager = 1'b0;
   bit         hold_rsp = 1'b0;
   int         bytes_sent = 0;

   sip_message_boundary_finder_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   sip_frame_monitor u_monitor (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .mismatches      (mismatches),
      .answers_waiting (answers_waiting)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hang detection: any transaction on either channel restarts the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- buffer assembly

   function automatic void put_text(input string s);
      for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
   endfunction

   function automatic void put_crlf();
      frame_bytes.push_back(CHAR_CR);
      frame_bytes.push_back(CHAR_LF);
   endfunction

   // printable filler never holds cr or lf, so it cannot end a header by accident
   function automatic void put_printable(input int n);
      repeat (n) frame_bytes.push_back(8'($urandom_range(32, 126)));
   endfunction

   function automatic void put_noise(input int n);
      repeat (n) frame_bytes.push_back(8'($urandom_range(0, 255)));
   endfunction

   function automatic void put_length_line(input string value_text);
      put_text("Content-Length: ");
      put_text(value_text);
      put_crlf();
   endfunction

   // ---------------------------------------------------------------- byte driving

   // one byte per transaction; unless eager, the sender may drop req_tvalid before each
   task automatic send_byte(input logic [7:0] b, input logic l);
      int gap;
      gap = sender_eager ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= l;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   // sends the assembled buffer with tlast on its final byte
   task automatic send_frame(input bit eager_only);
      int n;
      if (frame_bytes.size() == 0) frame_bytes.push_back(8'($urandom_range(0, 255)));
      n = frame_bytes.size();
      sender_eager = eager_only || ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n; i++) send_byte(frame_bytes[i], i == n - 1);
      frame_bytes.delete();
   endtask

   // ---------------------------------------------------------------- directed buffers

   task automatic run_directed();
      // keep-alive forms: a single nul, one crlf, crlf pairs ahead of a request,
      // a mix of nul and crlf
      frame_bytes.push_back(CHAR_NUL);
      send_frame(1'b0);
      put_crlf();
      send_frame(1'b0);
      put_crlf(); put_crlf(); put_text("INVITE");
      send_frame(1'b0);
      frame_bytes.push_back(CHAR_NUL); put_crlf(); frame_bytes.push_back(CHAR_NUL);
      send_frame(1'b0);
      // a lone cr ends the keep-alive run and is not counted
      frame_bytes.push_back(CHAR_CR);
      send_frame(1'b0);
      put_crlf(); frame_bytes.push_back(CHAR_CR); put_text("X");
      send_frame(1'b0);
      // top byte value on its own
      frame_bytes.push_back(8'hff);
      send_frame(1'b0);
      // plain messages: empty body, exact body, body cut short
      put_length_line("0"); put_crlf();
      send_frame(1'b0);
      put_length_line("3"); put_crlf(); put_printable(3);
      send_frame(1'b0);
      put_length_line("5"); put_crlf(); put_printable(2);
      send_frame(1'b0);
      // a leading blank, a tab and a plus sign ahead of the digits, other headers around
      put_text("Via: a"); put_crlf();
      put_text("Content-Length:  "); frame_bytes.push_back(CHAR_TAB); put_text("+7"); put_crlf();
      put_text("X: y"); put_crlf(); put_crlf(); put_printable(9);
      send_frame(1'b0);
      // minus zero is zero, minus anything else is incomplete
      put_length_line("-0"); put_crlf();
      send_frame(1'b0);
      put_length_line("-3"); put_crlf(); put_printable(3);
      send_frame(1'b0);
      // twelve characters of value text get flagged, eleven saturate quietly
      put_length_line("123456789012"); put_crlf();
      send_frame(1'b0);
      put_length_line("12345678901"); put_crlf(); put_printable(4);
      send_frame(1'b0);
      // digits stop at the first non-digit
      put_length_line("12ab"); put_crlf(); put_printable(12);
      send_frame(1'b0);
      // empty value made of carriage returns before the line end
      put_text("Content-Length: ");
      frame_bytes.push_back(CHAR_CR); frame_bytes.push_back(CHAR_CR); frame_bytes.push_back(CHAR_LF);
      put_crlf();
      send_frame(1'b0);
      // a false start on the header name, then a near miss of it
      put_text("C"); put_length_line("0"); put_crlf();
      send_frame(1'b0);
      put_text("Content-Lengt 4"); put_crlf(); put_crlf(); put_printable(4);
      send_frame(1'b0);
      // no digits at all, and a bare plus sign
      put_length_line("x"); put_crlf();
      send_frame(1'b0);
      put_length_line("+"); put_crlf(); put_printable(1);
      send_frame(1'b0);
      // a stray cr delays the header end
      put_length_line("2"); frame_bytes.push_back(CHAR_CR); put_crlf(); put_crlf(); put_printable(2);
      send_frame(1'b0);
   endtask

   // ---------------------------------------------------------------- random buffers

   task automatic build_random_frame();
      int pick;
      int value;
      int slack;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         // keep-alive run, sometimes with a lone cr or other bytes behind it
         repeat ($urandom_range(1, 5)) begin
            if ($urandom_range(0, 1) != 0) put_crlf();
            else frame_bytes.push_back(CHAR_NUL);
         end
         case ($urandom_range(0, 2))
            0: ;
            1: frame_bytes.push_back(CHAR_CR);
            default: put_noise($urandom_range(1, 10));
         endcase
      end else if (pick < 75) begin
         // well-formed message with random headers, value and body
         repeat ($urandom_range(0, 2)) begin
            put_printable($urandom_range(1, 8));
            put_crlf();
         end
         put_text("Content-Length: ");
         repeat ($urandom_range(0, 2))
            frame_bytes.push_back(($urandom_range(0, 1) != 0) ? CHAR_SPACE : CHAR_TAB);
         case ($urandom_range(0, 9))
            0: frame_bytes.push_back(CHAR_PLUS);
            1: frame_bytes.push_back(CHAR_MINUS);
            default: ;
         endcase
         if ($urandom_range(0, 7) == 0) begin
            // long digit strings reach saturation and the over-long flag
            repeat ($urandom_range(5, 13)) frame_bytes.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
            value = $urandom_range(0, 10);
         end else begin
            value = $urandom_range(0, 24);
            put_text($sformatf("%0d", value));
         end
         if ($urandom_range(0, 9) == 0) put_printable($urandom_range(1, 3));
         put_crlf();
         repeat ($urandom_range(0, 2)) begin
            put_printable($urandom_range(1, 8));
            put_crlf();
         end
         put_crlf();
         slack = int'($urandom_range(0, 9)) - 3;
         if (value + slack > 0) put_printable(value + slack);
         if ($urandom_range(0, 9) == 0)
            frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (pick < 90) begin
         // broken framing
         case ($urandom_range(0, 3))
            0: begin
               put_text("Content-Len");
               put_printable($urandom_range(1, 4));
               put_crlf(); put_crlf();
               put_printable($urandom_range(0, 6));
            end
            1: begin
               // cr inside the value text
               put_text("Content-Length: ");
               put_text($sformatf("%0d", $urandom_range(0, 9)));
               frame_bytes.push_back(CHAR_CR);
               put_printable($urandom_range(1, 2));
               put_crlf(); put_crlf();
               put_printable($urandom_range(0, 10));
            end
            2: begin
               // header end missing or cut after cr lf cr
               put_length_line($sformatf("%0d", $urandom_range(0, 9)));
               put_printable($urandom_range(0, 5));
               if ($urandom_range(0, 1) != 0) begin
                  put_crlf();
                  frame_bytes.push_back(CHAR_CR);
               end
            end
            default: begin
               put_text("Conte");
               put_noise($urandom_range(0, 4));
               put_length_line("4");
               put_crlf();
               frame_bytes.push_back(CHAR_CR);
               put_printable($urandom_range(2, 6));
            end
         endcase
      end else begin
         put_noise($urandom_range(1, 40));
      end
   endtask

   // ---------------------------------------------------------------- result side

   initial begin
      int gap;
      bit rsp_eager;
      rsp_eager = 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            // long hold-off so the byte queue fills and req_tready drops
            hold_rsp = 1'b0;
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end else begin
            if ($urandom_range(0, 7) == 0) rsp_eager = !rsp_eager;
            gap = rsp_eager ? 0 : $urandom_range(0, 8);
            if (gap != 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // ---------------------------------------------------------------- stimulus and verdict

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      // back-pressure: short buffers sent flat out while the result side holds off
      hold_rsp = 1'b1;
      repeat (16) begin
         frame_bytes.push_back(8'($urandom_range(0, 255)));
         send_frame(1'b1);
      end

      while (bytes_sent < TOTAL_BYTES) begin
         build_random_frame();
         send_frame(1'b0);
      end

      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
      @(posedge clock);
      while (answers_waiting != 0) @(posedge clock);
      // spare cycles so that any extra result is seen before the verdict
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire
